// ===== rtl/core/fxo_ring_polarity_monitor_assert.svh =====
// Assertion macros shared by the FXO ring and polarity monitor RTL.
`ifndef FXO_RING_POLARITY_MONITOR_ASSERT_SVH
`define FXO_RING_POLARITY_MONITOR_ASSERT_SVH

`ifndef SYNTHESIS

// Condition that must hold at every clock edge outside reset.
`define FRPM_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: condition does not hold");

// Consequent that must hold in the same cycle as the antecedent.
`define FRPM_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication does not hold");

// Consequent that must hold in the cycle after the antecedent.
`define FRPM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication does not hold");

`else

`define FRPM_ASSERT_ALWAYS(label, cond)
`define FRPM_ASSERT_IMPLY(label, ante, cons)
`define FRPM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/core/frpm_pkg.sv =====
// Types and constants of the FXO ring and polarity monitor.
package frpm_pkg;

    // Monitor byte check.
    localparam logic [7:0] MON_MASK     = 8'h9b;
    localparam logic [7:0] CODE_OFFHOOK = 8'h09;
    localparam logic [7:0] CODE_ONHOOK  = 8'h08;

    // Polarity lives in bit 1 of the status byte.
    localparam int unsigned POL_BIT = 1;

    // Ring event codes.
    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_START = 2'd1;
    localparam logic [1:0] EV_CAR   = 2'd2;
    localparam logic [1:0] EV_RING  = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_TICK_STEP    = 2'd0;
    localparam logic [1:0] REG_CAR_WINDOW   = 2'd1;
    localparam logic [1:0] REG_RING_TIMEOUT = 2'd2;

    // Configuration reset values.
    localparam logic [7:0]  RST_TICK_STEP    = 8'd8;
    localparam logic [15:0] RST_CAR_WINDOW   = 16'd640;
    localparam logic [15:0] RST_RING_TIMEOUT = 16'd4000;

    localparam logic [15:0] CNT_MAX = 16'hffff;

    typedef struct packed {
        logic [1:0] channel;
        logic       line_offhook;
        logic [7:0] monitor_byte;
        logic [7:0] ring_status_byte;
        logic [7:0] polarity_byte;
    } frpm_in_t;

    typedef struct packed {
        logic [1:0] ring_event;
        logic       polarity_event;
        logic       new_polarity;
        logic       daa_reset;
        logic       hook_write;
        logic [7:0] hook_write_value;
        logic       ring_clear_write;
        logic [7:0] ring_clear_value;
    } frpm_out_t;

    typedef struct packed {
        logic [7:0]  tick_step;
        logic [15:0] car_window;
        logic [15:0] ring_timeout;
    } frpm_cfg_t;

endpackage

// ===== rtl/core/frpm_chan_unit.sv =====
// Per-channel ring and polarity state with the tick evaluation logic.
`include "fxo_ring_polarity_monitor_assert.svh"

module frpm_chan_unit #(
    parameter int unsigned CHANNELS = 4,
    parameter int unsigned RING_BIT = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  frpm_pkg::frpm_cfg_t cfg,
    input  logic                update,
    input  frpm_pkg::frpm_in_t  item,
    output frpm_pkg::frpm_out_t res
);
    import frpm_pkg::*;

    localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [7:0] DETECT_MASK = 8'(1) << RING_BIT;

    logic        flag_reg [CHANNELS];
    logic [15:0] cnt_reg  [CHANNELS];
    logic        pol_reg  [CHANNELS];

    logic        flag_next;
    logic [15:0] cnt_next;
    logic        pol_next;

    logic [CH_W-1:0] idx;
    logic            in_range;
    logic            detect;
    logic [16:0]     sum;
    logic [15:0]     sum_sat;
    logic [7:0]      hook_value;
    logic            cur_pol;

    assign idx      = CH_W'(item.channel);
    assign in_range = (32'(item.channel) < CHANNELS);
    assign detect   = (item.ring_status_byte & DETECT_MASK) != 8'd0;
    assign sum      = {1'b0, cnt_reg[idx]} + {9'd0, cfg.tick_step};
    assign sum_sat  = sum[16] ? CNT_MAX : sum[15:0];
    assign cur_pol  = item.polarity_byte[POL_BIT];

    // Evaluate one tick against the addressed channel's state.
    always_comb
    begin
        flag_next  = flag_reg[idx];
        cnt_next   = cnt_reg[idx];
        pol_next   = cur_pol;
        hook_value = item.line_offhook ? CODE_OFFHOOK : CODE_ONHOOK;
        res        = '0;

        res.daa_reset        = (item.monitor_byte == 8'd0);
        res.hook_write_value = hook_value;
        res.hook_write       = (item.monitor_byte & MON_MASK) != hook_value;
        res.new_polarity     = cur_pol;
        res.polarity_event   = (cur_pol != pol_reg[idx]);

        if (!item.line_offhook)
        begin
            if (detect)
            begin
                res.ring_clear_write = 1'b1;
                res.ring_clear_value = item.ring_status_byte & ~DETECT_MASK;
                cnt_next             = 16'd0;
                flag_next            = !flag_reg[idx];
                if (!flag_reg[idx])
                begin
                    res.ring_event = EV_START;
                end
                else if (cnt_reg[idx] <= cfg.car_window)
                begin
                    res.ring_event = EV_CAR;
                end
                else
                begin
                    res.ring_event = EV_RING;
                end
            end
            else if (flag_reg[idx])
            begin
                // Quiet tick of a pending ring: advance and check the timeout.
                if (sum_sat >= cfg.ring_timeout)
                begin
                    flag_next = 1'b0;
                    cnt_next  = 16'd0;
                end
                else
                begin
                    cnt_next = sum_sat;
                end
            end
        end

        // A channel beyond the table gives an all-zero result.
        if (!in_range)
        begin
            res = '0;
        end
    end

    // Channel state update on each committed tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                flag_reg[i] <= 1'b0;
                cnt_reg[i]  <= 16'd0;
                pol_reg[i]  <= 1'b0;
            end
        end
        else if (update && in_range)
        begin
            flag_reg[idx] <= flag_next;
            cnt_reg[idx]  <= cnt_next;
            pol_reg[idx]  <= pol_next;
        end
    end

    // An idle channel always holds a cleared counter.
    `FRPM_ASSERT_IMPLY(a_idle_cnt_zero, in_range && !flag_reg[idx], cnt_reg[idx] == 16'd0)
    // After a committed tick the channel's polarity matches that tick.
    `FRPM_ASSERT_NEXT(a_pol_tracks, update && in_range, pol_reg[$past(idx)] == $past(cur_pol))
    // Ring events are reported exactly when the detect bit is cleared.
    `FRPM_ASSERT_ALWAYS(a_event_clear, (res.ring_event != EV_NONE) == res.ring_clear_write)

endmodule

// ===== rtl/core/fxo_ring_polarity_monitor.sv =====
// FXO ring and polarity monitor top level: tick and result channels, config registers.
// A tick moves from the input register on to the result register when that is free.
// Throughput: one tick per cycle while the result side does not stall.
// Back-to-back ticks on one channel see the state left by the previous tick.
// Reset clears the pipeline valids and all channel state and loads config defaults.
`include "fxo_ring_polarity_monitor_assert.svh"

module fxo_ring_polarity_monitor #(
    parameter int unsigned CHANNELS = 4,
    parameter int unsigned RING_BIT = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tick_valid,
    output logic                tick_stall,
    input  frpm_pkg::frpm_in_t  tick,
    output logic                result_valid,
    input  logic                result_stall,
    output frpm_pkg::frpm_out_t result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    import frpm_pkg::*;

    logic      s1_valid_reg;
    logic      s1_valid_next;
    frpm_in_t  s1_item_reg;
    logic      result_valid_reg;
    logic      result_valid_next;
    frpm_out_t result_reg;
    frpm_cfg_t cfg_reg;
    frpm_cfg_t cfg_next;
    frpm_out_t eval_res;
    logic      advance;
    logic      commit;
    logic      take;

    // Handshake control: the result register frees up when it is empty or taken.
    assign advance      = !result_valid_reg || !result_stall;
    assign tick_stall   = s1_valid_reg && !advance;
    assign take         = tick_valid && !tick_stall;
    assign commit       = s1_valid_reg && advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign cfg_ready    = 1'b1;

    assign s1_valid_next     = tick_stall ? s1_valid_reg : tick_valid;
    assign result_valid_next = advance ? s1_valid_reg : result_valid_reg;

    // Configuration register write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TICK_STEP:    cfg_next.tick_step    = cfg_data[7:0];
                REG_CAR_WINDOW:   cfg_next.car_window   = cfg_data;
                REG_RING_TIMEOUT: cfg_next.ring_timeout = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    frpm_chan_unit #(
        .CHANNELS (CHANNELS),
        .RING_BIT (RING_BIT)
    ) u_chan (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .update (commit),
        .item   (s1_item_reg),
        .res    (eval_res)
    );

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg          <= 1'b0;
            result_valid_reg      <= 1'b0;
            cfg_reg.tick_step     <= RST_TICK_STEP;
            cfg_reg.car_window    <= RST_CAR_WINDOW;
            cfg_reg.ring_timeout  <= RST_RING_TIMEOUT;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
            cfg_reg          <= cfg_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_item_reg <= tick;
        end
        if (commit)
        begin
            result_reg <= eval_res;
        end
    end

    // The input side stalls only while an item waits in the input register.
    `FRPM_ASSERT_IMPLY(a_stall_needs_item, tick_stall, s1_valid_reg && result_valid_reg)
    // A committed tick always lands in the result register.
    `FRPM_ASSERT_NEXT(a_commit_lands, commit, result_valid_reg)
    // A zero monitor byte always asks for a monitor rewrite as well.
    `FRPM_ASSERT_IMPLY(a_reset_rewrites, result_valid_reg && result_reg.daa_reset,
                       result_reg.hook_write)

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the FXO ring and polarity monitor.
`timescale 1ns / 1ps

module tb_top;
    import frpm_pkg::*;

    localparam int unsigned DETECT_BIT = 7;
    localparam int unsigned NUM_CH     = 4;
    localparam int unsigned STALL_LIMIT = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        tick_valid = 1'b0;
    logic        tick_stall;
    frpm_in_t    tick = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    frpm_out_t   result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    // Ticks waiting to be sent and line reports waiting to come back.
    frpm_in_t  pending_ticks[$];
    frpm_out_t expected_reports[$];
    int unsigned queued_count = 0;
    int unsigned checked_count = 0;
    int unsigned error_count = 0;
    bit no_gaps = 1'b0;

    // Shadow of the line state and the register settings.
    logic        ring_armed[NUM_CH];
    logic [15:0] ring_cnt[NUM_CH];
    logic        last_pol[NUM_CH];
    logic [7:0]  cfg_step = RST_TICK_STEP;
    logic [15:0] cfg_car_window = RST_CAR_WINDOW;
    logic [15:0] cfg_timeout = RST_RING_TIMEOUT;

    // Quiet ticks left before the next detect, per channel, for ring sequences.
    int unsigned quiet_left[NUM_CH];

    fxo_ring_polarity_monitor uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_stall   (tick_stall),
        .tick         (tick),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned draw_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 20);
    endfunction

    // Work out the line report for one tick and advance the shadow state.
    function automatic frpm_out_t monitor_tick(frpm_in_t t);
        frpm_out_t   rep;
        logic [16:0] sum;
        logic        pol;
        int unsigned ch;
        rep = '0;
        ch = 32'(t.channel);
        rep.daa_reset = (t.monitor_byte == 8'h00);
        rep.hook_write_value = t.line_offhook ? CODE_OFFHOOK : CODE_ONHOOK;
        rep.hook_write = ((t.monitor_byte & MON_MASK) != rep.hook_write_value);
        if (!t.line_offhook)
        begin
            if (t.ring_status_byte[DETECT_BIT])
            begin
                rep.ring_clear_write = 1'b1;
                rep.ring_clear_value = t.ring_status_byte;
                rep.ring_clear_value[DETECT_BIT] = 1'b0;
                if (!ring_armed[ch])
                begin
                    ring_armed[ch] = 1'b1;
                    rep.ring_event = EV_START;
                end
                else
                begin
                    rep.ring_event = (ring_cnt[ch] <= cfg_car_window) ? EV_CAR : EV_RING;
                    ring_armed[ch] = 1'b0;
                end
                ring_cnt[ch] = '0;
            end
            else if (ring_armed[ch])
            begin
                // Saturating add, then drop the pending ring on timeout.
                sum = {1'b0, ring_cnt[ch]} + {9'b0, cfg_step};
                if (sum > {1'b0, CNT_MAX})
                    sum = {1'b0, CNT_MAX};
                if (sum >= {1'b0, cfg_timeout})
                begin
                    ring_armed[ch] = 1'b0;
                    sum = '0;
                end
                ring_cnt[ch] = sum[15:0];
            end
        end
        pol = t.polarity_byte[POL_BIT];
        rep.new_polarity = pol;
        if (pol != last_pol[ch])
        begin
            rep.polarity_event = 1'b1;
            last_pol[ch] = pol;
        end
        return rep;
    endfunction

    // Tick driver: holds a beat while stalled, otherwise sends the next one after a gap.
    int unsigned send_gap = 0;
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            tick_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (tick_valid && !tick_stall)
                expected_reports.push_back(monitor_tick(tick));
            if (!(tick_valid && tick_stall))
            begin
                if (send_gap != 0 || pending_ticks.size() == 0)
                begin
                    if (send_gap != 0)
                        send_gap--;
                    tick_valid <= 1'b0;
                end
                else
                begin
                    tick <= pending_ticks.pop_front();
                    tick_valid <= 1'b1;
                    send_gap = draw_gap();
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            if (error_count < 10)
                $display("mismatch in %s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    // Report monitor: checks each accepted beat and stalls at random.
    int unsigned stall_left = 0;
    always @(posedge clk)
    begin
        frpm_out_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_reports.size() == 0)
                begin
                    if (error_count < 10)
                        $display("unexpected report %h", result);
                    error_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    checked_count++;
                    check_field("ring_event", 8'(want.ring_event), 8'(result.ring_event));
                    check_field("polarity_event", 8'(want.polarity_event),
                                8'(result.polarity_event));
                    check_field("new_polarity", 8'(want.new_polarity),
                                8'(result.new_polarity));
                    check_field("daa_reset", 8'(want.daa_reset), 8'(result.daa_reset));
                    check_field("hook_write", 8'(want.hook_write), 8'(result.hook_write));
                    check_field("hook_write_value", want.hook_write_value,
                                result.hook_write_value);
                    check_field("ring_clear_write", 8'(want.ring_clear_write),
                                8'(result.ring_clear_write));
                    check_field("ring_clear_value", want.ring_clear_value,
                                result.ring_clear_value);
                end
            end
            if (stall_left != 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
                stall_left = draw_gap();
            end
        end
    end

    // Watchdog: counts cycles without any beat while work is outstanding.
    int unsigned quiet_cycles = 0;
    always @(posedge clk)
    begin
        if (!rst_n || (tick_valid && !tick_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready)
            || (checked_count == queued_count && !cfg_valid))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles == STALL_LIMIT)
            begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    function automatic frpm_in_t tick_of(logic [1:0] ch, logic off, logic [7:0] mon,
                                         logic [7:0] ring, logic [7:0] pol);
        frpm_in_t t;
        t.channel = ch;
        t.line_offhook = off;
        t.monitor_byte = mon;
        t.ring_status_byte = ring;
        t.polarity_byte = pol;
        return t;
    endfunction

    task automatic queue_tick(input frpm_in_t t);
        pending_ticks.push_back(t);
        queued_count++;
    endtask

    // On-hook tick for a ring sequence; the monitor byte is usually a valid hook code.
    function automatic frpm_in_t line_tick(logic [1:0] ch, logic detect);
        frpm_in_t    t;
        int unsigned r;
        t = tick_of(ch, 1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
        r = $urandom_range(0, 99);
        if (r < 8)
            t.monitor_byte = 8'h00;
        else if (r < 70)
            t.monitor_byte = CODE_ONHOOK | (8'($urandom) & ~MON_MASK);
        t.ring_status_byte[DETECT_BIT] = detect;
        return t;
    endfunction

    // Random part: interleaved ring sequences per channel, plus some noise.
    task automatic queue_random(input int unsigned count);
        frpm_in_t    t;
        int unsigned ch;
        int unsigned lim;
        repeat (count)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                t = tick_of(2'($urandom), 1'($urandom), 8'($urandom), 8'($urandom),
                            8'($urandom));
                if ($urandom_range(0, 1) == 0)
                    t.monitor_byte = (t.line_offhook ? CODE_OFFHOOK : CODE_ONHOOK)
                                     | (8'($urandom) & ~MON_MASK);
            end
            else
            begin
                ch = $urandom_range(0, NUM_CH - 1);
                if (quiet_left[ch] == 0)
                begin
                    t = line_tick(2'(ch), 1'b1);
                    lim = cfg_timeout / cfg_step + 3;
                    if (lim > 40)
                        lim = 40;
                    quiet_left[ch] = $urandom_range(0, lim);
                end
                else
                begin
                    t = line_tick(2'(ch), 1'b0);
                    quiet_left[ch]--;
                end
            end
            queue_tick(t);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        case (idx)
            REG_TICK_STEP:    cfg_step = data[7:0];
            REG_CAR_WINDOW:   cfg_car_window = data;
            REG_RING_TIMEOUT: cfg_timeout = data;
            default:          ;
        endcase
    endtask

    // Sender holds off until every report has come back.
    task automatic wait_drained();
        while (checked_count != queued_count)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        logic [7:0] step;
        int unsigned i;
        for (i = 0; i < NUM_CH; i++)
        begin
            ring_armed[i] = 1'b0;
            ring_cnt[i] = '0;
            last_pol[i] = 1'b0;
            quiet_left[i] = 0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed ticks at reset settings: byte extremes, hook codes, CAR and off-hook.
        queue_tick(tick_of(2'd0, 1'b0, 8'h00, 8'h00, 8'h00));
        queue_tick(tick_of(2'd1, 1'b1, 8'hff, 8'hff, 8'hff));
        queue_tick(tick_of(2'd2, 1'b0, 8'h08, 8'h80, 8'h02));
        queue_tick(tick_of(2'd2, 1'b0, 8'h6c, 8'hff, 8'h00));
        queue_tick(tick_of(2'd3, 1'b1, 8'h09, 8'h7f, 8'hfd));
        queue_tick(tick_of(2'd3, 1'b0, 8'h09, 8'h80, 8'hfd));
        queue_tick(tick_of(2'd3, 1'b0, 8'h08, 8'h00, 8'h02));
        queue_tick(tick_of(2'd3, 1'b1, 8'h9b, 8'h80, 8'h02));
        queue_tick(tick_of(2'd3, 1'b0, 8'h08, 8'h81, 8'h00));
        queue_tick(tick_of(2'd0, 1'b1, 8'h6d, 8'h00, 8'h02));
        queue_tick(tick_of(2'd0, 1'b0, 8'h00, 8'h7f, 8'h02));
        queue_tick(tick_of(2'd1, 1'b0, 8'h64, 8'h80, 8'hfd));
        queue_tick(tick_of(2'd1, 1'b1, 8'h00, 8'h80, 8'h00));
        queue_tick(tick_of(2'd1, 1'b0, 8'hf7, 8'h55, 8'haa));
        queue_tick(tick_of(2'd1, 1'b0, 8'h08, 8'hd5, 8'h55));
        queue_tick(tick_of(2'd2, 1'b1, 8'hf6, 8'h2a, 8'hff));
        queue_tick(tick_of(2'd0, 1'b0, 8'h01, 8'hff, 8'h00));
        queue_tick(tick_of(2'd0, 1'b0, 8'h80, 8'hff, 8'h02));
        queue_random(200);
        wait_drained();

        // Extremes: largest step, zero CAR window, every quiet tick times out.
        write_reg(REG_TICK_STEP, 16'h00ff);
        write_reg(REG_CAR_WINDOW, 16'h0000);
        write_reg(REG_RING_TIMEOUT, 16'h0001);
        write_reg(2'd3, 16'h5a5a);
        queue_random(150);
        wait_drained();

        // Widest window and timeout, with a long quiet run that saturates the counter.
        no_gaps = 1'b1;
        write_reg(REG_TICK_STEP, {8'hab, 8'd254});
        write_reg(REG_CAR_WINDOW, 16'hffff);
        write_reg(REG_RING_TIMEOUT, 16'hffff);
        queue_tick(line_tick(2'd0, 1'b1));
        repeat (262) queue_tick(line_tick(2'd0, 1'b0));
        queue_tick(line_tick(2'd0, 1'b1));
        no_gaps = 1'b0;
        queue_random(40);
        wait_drained();

        // Random settings, scaled so that CAR, ring and timeout all occur.
        for (i = 0; i < 5; i++)
        begin
            no_gaps = (i == 2);
            step = 8'($urandom_range(1, 255));
            write_reg(REG_TICK_STEP, {8'($urandom), step});
            write_reg(REG_CAR_WINDOW, 16'(step * $urandom_range(1, 12)));
            write_reg(REG_RING_TIMEOUT,
                      16'(cfg_car_window + step * $urandom_range(1, 15)));
            queue_random(180);
            wait_drained();
        end

        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
